### src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared widths, register map and beat types of the line pixel rasterizer.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int CRD_W = 16;  // coordinate width on the ports and inside
  localparam int DLT_W = 17;  // delta width, |a - b| of two coordinates
  localparam int ERR_W = 18;  // signed error term
  localparam int CLR_W = 16;  // RGB565 color
  localparam int DIM_W = 13;  // screen dimension registers
  localparam int ADR_W = 3;   // byte address of two 32-bit registers
  localparam int DAT_W = 32;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(240);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(320);

  // Classified command from the front part to the back part
  typedef struct packed {
    logic                    is_step;
    logic                    steep;
    logic                    step_down;
    logic signed [CRD_W-1:0] major_pos;
    logic signed [CRD_W-1:0] minor_pos;
    logic signed [CRD_W-1:0] major_end;
    logic        [DLT_W-1:0] delta_major;
    logic        [DLT_W-1:0] delta_minor;
    logic        [CLR_W-1:0] color;
  } cmd_t;

  // One emitted pixel
  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic        [CLR_W-1:0] color;
    logic                    on_screen;
    logic                    last;
  } pix_t;

endpackage

### src/lpr_queue.sv
// ----------------------------------------------------------------------------
// lpr_queue
// Two-entry queue; the head entry is shown while empty is low.
// ----------------------------------------------------------------------------
module lpr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### src/lpr_front.sv
// ----------------------------------------------------------------------------
// lpr_front
// Accepts input beats, sets up a start (steep test, endpoint order, deltas)
// and queues the classified command for the back part.
// ----------------------------------------------------------------------------
module lpr_front
  import lpr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    op,
  input  logic signed [CRD_W-1:0] x_start,
  input  logic signed [CRD_W-1:0] y_start,
  input  logic signed [CRD_W-1:0] x_end,
  input  logic signed [CRD_W-1:0] y_end,
  input  logic        [CLR_W-1:0] line_color,
  input  logic                    cmd_pop,
  output logic                    cmd_empty,
  output cmd_t                    cmd_head
);

  localparam int SH = CRD_W - COORD_BITS;

  // keep the low COORD_BITS bits, sign-extended
  function automatic logic signed [CRD_W-1:0] sext(input logic signed [CRD_W-1:0] v);
    logic signed [CRD_W-1:0] t;
    t = v <<< SH;
    return t >>> SH;
  endfunction

  logic signed [CRD_W-1:0] x0, y0, x1, y1;
  logic signed [DLT_W-1:0] dx, dy, dmaj, dmin;
  logic        [DLT_W-1:0] adx, ady;
  logic signed [CRD_W-1:0] a0, a1, b0, b1;
  logic                    steep;
  logic                    order;
  cmd_t                    cmd;

  assign x0 = sext(x_start);
  assign y0 = sext(y_start);
  assign x1 = sext(x_end);
  assign y1 = sext(y_end);

  // steep test and endpoint ordering
  always_comb begin
    dx    = DLT_W'(x1) - DLT_W'(x0);
    dy    = DLT_W'(y1) - DLT_W'(y0);
    adx   = dx[DLT_W-1] ? DLT_W'(-dx) : DLT_W'(dx);
    ady   = dy[DLT_W-1] ? DLT_W'(-dy) : DLT_W'(dy);
    steep = ady > adx;
    a0    = steep ? y0 : x0;
    a1    = steep ? y1 : x1;
    b0    = steep ? x0 : y0;
    b1    = steep ? x1 : y1;
    dmaj  = steep ? dy : dx;
    dmin  = steep ? dx : dy;
    order = dmaj[DLT_W-1];  // endpoints swap when major axis runs backward

    cmd.is_step     = op;
    cmd.steep       = steep;
    cmd.major_pos   = order ? a1 : a0;
    cmd.minor_pos   = order ? b1 : b0;
    cmd.major_end   = order ? a0 : a1;
    cmd.delta_major = steep ? ady : adx;
    cmd.delta_minor = steep ? adx : ady;
    // minor moves down unless the ordered minor coordinate increases
    cmd.step_down   = order ? (dmin >= 0) : (dmin <= 0);
    cmd.color       = line_color;
  end

  // command queue to the back part
  lpr_queue #(
    .W($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (cmd),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_head)
  );

endmodule

### src/lpr_back.sv
// ----------------------------------------------------------------------------
// lpr_back
// Holds the active line and runs the error-term stepper: one pixel per
// step command, pushed into the result queue.
// ----------------------------------------------------------------------------
module lpr_back
  import lpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [DIM_W-1:0] screen_width,
  input  logic [DIM_W-1:0] screen_height,
  input  logic             cmd_empty,
  input  cmd_t             cmd_head,
  output logic             cmd_pop,
  input  logic             pop,
  output logic             empty,
  output pix_t             pix_head
);

  logic                    busy;
  logic                    axes_swapped;
  logic signed [CRD_W-1:0] major_pos;
  logic signed [CRD_W-1:0] minor_pos;
  logic signed [CRD_W-1:0] major_end;
  logic        [DLT_W-1:0] delta_major;
  logic        [DLT_W-1:0] delta_minor;
  logic signed [ERR_W-1:0] error_term;
  logic                    minor_step_down;
  logic        [CLR_W-1:0] held_color;

  logic                    out_full;
  logic                    emit;
  logic                    last;
  logic signed [ERR_W-1:0] err_sub;
  logic signed [ERR_W-1:0] error_term_next;
  logic signed [CRD_W-1:0] minor_pos_next;
  pix_t                    pix;

  // a step on an active line needs room in the result queue
  assign emit    = !cmd_empty && cmd_head.is_step && busy;
  assign cmd_pop = !cmd_empty && !(emit && out_full);

  // pixel and stepper arithmetic
  always_comb begin
    last            = major_pos >= major_end;
    pix.x           = axes_swapped ? minor_pos : major_pos;
    pix.y           = axes_swapped ? major_pos : minor_pos;
    pix.color       = held_color;
    pix.last        = last;
    pix.on_screen   = !pix.x[CRD_W-1] && !pix.y[CRD_W-1] &&
                      ($unsigned(pix.x) < CRD_W'(screen_width)) &&
                      ($unsigned(pix.y) < CRD_W'(screen_height));
    err_sub         = error_term - ERR_W'(delta_minor);
    error_term_next = err_sub;
    minor_pos_next  = minor_pos;
    if (err_sub[ERR_W-1]) begin
      error_term_next = err_sub + ERR_W'(delta_major);
      minor_pos_next  = minor_step_down ? minor_pos - CRD_W'(1) : minor_pos + CRD_W'(1);
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      axes_swapped    <= 1'b0;
      major_pos       <= '0;
      minor_pos       <= '0;
      major_end       <= '0;
      delta_major     <= '0;
      delta_minor     <= '0;
      error_term      <= '0;
      minor_step_down <= 1'b0;
      held_color      <= '0;
    end else if (cmd_pop) begin
      if (!cmd_head.is_step) begin
        busy            <= 1'b1;
        axes_swapped    <= cmd_head.steep;
        major_pos       <= cmd_head.major_pos;
        minor_pos       <= cmd_head.minor_pos;
        major_end       <= cmd_head.major_end;
        delta_major     <= cmd_head.delta_major;
        delta_minor     <= cmd_head.delta_minor;
        error_term      <= ERR_W'(cmd_head.delta_major >> 1);
        minor_step_down <= cmd_head.step_down;
        held_color      <= cmd_head.color;
      end else if (busy) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          error_term <= error_term_next;
          minor_pos  <= minor_pos_next;
          major_pos  <= major_pos + CRD_W'(1);
        end
      end
    end
  end

  // result queue
  lpr_queue #(
    .W($bits(pix_t))
  ) u_pix_q (
    .clk   (clk),
    .rst   (rst),
    .push  (emit),
    .full  (out_full),
    .wdata (pix),
    .pop   (pop),
    .empty (empty),
    .rdata (pix_head)
  );

endmodule

### src/line_pixel_rasterizer_top.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_top
// Line rasterizer: turns a start beat and a series of step beats into the
// pixels of a line, each flagged on_screen against the programmed screen size.
//
// Input channel: push/full. op = 0 starts a line (endpoints and color, no
// result), op = 1 emits the next pixel of the active line; a step with no
// active line is dropped. Result channel: empty/pop, one beat per step
// carrying pixel_x, pixel_y, pixel_color, on_screen and last_pixel.
// Throughput is one input beat per cycle while full is low. A step passes
// through the command queue, and the stepper writes the result queue from
// the queue head. Both sides are two-entry queues, so a stalled receiver
// first backs up the stepper; full rises once both queues fill.
// Registers (APB, byte addresses): 0x0 screen_width, 0x4 screen_height,
// 13 bits each, reset 240 and 320; write them only while idle.
// Reset (rst, synchronous) empties both queues and ends any active line.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_top
  import lpr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic        [ADR_W-1:0] paddr,
  input  logic        [DAT_W-1:0] pwdata,
  output logic        [DAT_W-1:0] prdata,
  output logic                    pready,
  // input beats
  input  logic                    push,
  output logic                    full,
  input  logic                    op,
  input  logic signed [CRD_W-1:0] x_start,
  input  logic signed [CRD_W-1:0] y_start,
  input  logic signed [CRD_W-1:0] x_end,
  input  logic signed [CRD_W-1:0] y_end,
  input  logic        [CLR_W-1:0] line_color,
  // result beats
  output logic                    empty,
  input  logic                    pop,
  output logic signed [CRD_W-1:0] pixel_x,
  output logic signed [CRD_W-1:0] pixel_y,
  output logic        [CLR_W-1:0] pixel_color,
  output logic                    on_screen,
  output logic                    last_pixel
);

  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  reg_idx_t         reg_idx;
  logic             cmd_pop;
  logic             cmd_empty;
  cmd_t             cmd_head;
  pix_t             pix_head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RST;
      screen_height <= HEIGHT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_WIDTH:  screen_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: screen_height <= pwdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = DAT_W'(screen_width);
      REG_HEIGHT: prdata = DAT_W'(screen_height);
      default:    prdata = '0;
    endcase
  end

  lpr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .op         (op),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .line_color (line_color),
    .cmd_pop    (cmd_pop),
    .cmd_empty  (cmd_empty),
    .cmd_head   (cmd_head)
  );

  lpr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .cmd_empty     (cmd_empty),
    .cmd_head      (cmd_head),
    .cmd_pop       (cmd_pop),
    .pop           (pop),
    .empty         (empty),
    .pix_head      (pix_head)
  );

  assign pixel_x     = pix_head.x;
  assign pixel_y     = pix_head.y;
  assign pixel_color = pix_head.color;
  assign on_screen   = pix_head.on_screen;
  assign last_pixel  = pix_head.last;

endmodule

### tb/lpr_tb_pkg.sv
// ----------------------------------------------------------------------------
// lpr_tb_pkg
// Operation codes and a distance helper shared by the rasterizer testbench.
// ----------------------------------------------------------------------------
package lpr_tb_pkg;

  // op field of an input beat
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // distance between two coordinates
  function automatic int span(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage

### tb/lpr_pixel_checker.sv
// ----------------------------------------------------------------------------
// lpr_pixel_checker
// Watches the register port and both beat channels of the line rasterizer,
// traces each line on its own and compares every popped pixel with the
// oldest pixel it predicted. Reports the mismatch count and the number of
// pixels still owed by the block.
// ----------------------------------------------------------------------------
module lpr_pixel_checker
  import lpr_pkg::*;
  import lpr_tb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic        [ADR_W-1:0] paddr,
  input  logic        [DAT_W-1:0] pwdata,
  input  logic                    pready,
  input  logic                    push,
  input  logic                    full,
  input  logic                    op,
  input  logic signed [CRD_W-1:0] x_start,
  input  logic signed [CRD_W-1:0] y_start,
  input  logic signed [CRD_W-1:0] x_end,
  input  logic signed [CRD_W-1:0] y_end,
  input  logic        [CLR_W-1:0] line_color,
  input  logic                    empty,
  input  logic                    pop,
  input  logic signed [CRD_W-1:0] pixel_x,
  input  logic signed [CRD_W-1:0] pixel_y,
  input  logic        [CLR_W-1:0] pixel_color,
  input  logic                    on_screen,
  input  logic                    last_pixel,
  output int                      mismatch_count,
  output int                      pixels_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // screen size as last written
  logic        [DIM_W-1:0] width_q;
  logic        [DIM_W-1:0] height_q;

  // line being traced
  logic                    line_active;
  logic                    swapped;
  logic                    step_down;
  logic signed [CRD_W-1:0] major_q;
  logic signed [CRD_W-1:0] minor_q;
  logic signed [CRD_W-1:0] major_last;
  logic        [DLT_W-1:0] dmajor_q;
  logic        [DLT_W-1:0] dminor_q;
  logic signed [ERR_W-1:0] err_q;
  logic        [CLR_W-1:0] color_q;

  pix_t expected_pixels[$];
  int   fails = 0;

  // Bresenham trace: a start loads the line, a step predicts one pixel
  task automatic trace_line_beat(input logic kind,
                                 input logic signed [CRD_W-1:0] xa,
                                 input logic signed [CRD_W-1:0] ya,
                                 input logic signed [CRD_W-1:0] xb,
                                 input logic signed [CRD_W-1:0] yb,
                                 input logic [CLR_W-1:0] c);
    int   a0, b0, a1, b1, t, px, py, e;
    logic steep;
    pix_t pix;
    if (kind == OP_START) begin
      a0 = xa;
      b0 = ya;
      a1 = xb;
      b1 = yb;
      steep = span(b0, b1) > span(a0, a1);
      if (steep) begin
        t = a0; a0 = b0; b0 = t;
        t = a1; a1 = b1; b1 = t;
      end
      // major coordinate always increases
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      swapped     = steep;
      major_q     = CRD_W'(a0);
      minor_q     = CRD_W'(b0);
      major_last  = CRD_W'(a1);
      dmajor_q    = DLT_W'(a1 - a0);
      dminor_q    = DLT_W'(span(b0, b1));
      err_q       = ERR_W'((a1 - a0) / 2);
      step_down   = !(b0 < b1);
      color_q     = c;
      line_active = 1'b1;
    end else if (line_active) begin
      px = swapped ? minor_q : major_q;
      py = swapped ? major_q : minor_q;
      pix.x         = CRD_W'(px);
      pix.y         = CRD_W'(py);
      pix.color     = color_q;
      pix.on_screen = px >= 0 && py >= 0 && px < int'(width_q) && py < int'(height_q);
      pix.last      = major_q >= major_last;
      expected_pixels.push_back(pix);
      if (pix.last) begin
        line_active = 1'b0;
      end else begin
        e = int'(err_q) - int'(dminor_q);
        if (e < 0) begin
          minor_q = CRD_W'(int'(minor_q) + (step_down ? -1 : 1));
          e = e + int'(dmajor_q);
        end
        err_q   = ERR_W'(e);
        major_q = CRD_W'(int'(major_q) + 1);
      end
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fails++;
      $display("%0t: pixel %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pix_t want;
    if (rst) begin
      width_q     = WIDTH_RST;
      height_q    = HEIGHT_RST;
      line_active = 1'b0;
      swapped     = 1'b0;
      step_down   = 1'b0;
      major_q     = '0;
      minor_q     = '0;
      major_last  = '0;
      dmajor_q    = '0;
      dminor_q    = '0;
      err_q       = '0;
      color_q     = '0;
      expected_pixels.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[2]))
          REG_WIDTH:  width_q  = pwdata[DIM_W-1:0];
          REG_HEIGHT: height_q = pwdata[DIM_W-1:0];
        endcase
      end
      // result beat against the oldest prediction
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          fails++;
          $display("%0t: pixel beat with none expected, actual x=%0d y=%0d color=%h",
                   $time, pixel_x, pixel_y, pixel_color);
        end else begin
          want = expected_pixels.pop_front();
          compare_field("x", want.x, pixel_x);
          compare_field("y", want.y, pixel_y);
          compare_field("color", want.color, pixel_color);
          compare_field("on_screen", want.on_screen, on_screen);
          compare_field("last", want.last, last_pixel);
        end
      end
      // input beat
      if (push && !full)
        trace_line_beat(op, x_start, y_start, x_end, y_end, line_color);
    end
    pixels_due     <= expected_pixels.size();
    mismatch_count <= fails;
  end

endmodule

### tb/tb_line_pixel_rasterizer_top.sv
// ----------------------------------------------------------------------------
// tb_line_pixel_rasterizer_top
// Drives start and step beats into the line rasterizer: a directed set of
// corner cases, then random lines under several screen sizes and idling
// patterns on both channels. The checker beside the block predicts and
// compares; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_line_pixel_rasterizer_top
  import lpr_pkg::*;
  import lpr_tb_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS_PER_PHASE = 285;
  localparam int RUN_LIMIT       = 200000;
  localparam int SETTLE_CYCLES   = 8;

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic        [ADR_W-1:0] paddr;
  logic        [DAT_W-1:0] pwdata;
  logic        [DAT_W-1:0] prdata;
  logic                    pready;
  logic                    push;
  logic                    full;
  logic                    op;
  logic signed [CRD_W-1:0] x_start;
  logic signed [CRD_W-1:0] y_start;
  logic signed [CRD_W-1:0] x_end;
  logic signed [CRD_W-1:0] y_end;
  logic        [CLR_W-1:0] line_color;
  logic                    empty;
  logic                    pop;
  logic signed [CRD_W-1:0] pixel_x;
  logic signed [CRD_W-1:0] pixel_y;
  logic        [CLR_W-1:0] pixel_color;
  logic                    on_screen;
  logic                    last_pixel;
  int                      mismatch_count;
  int                      pixels_due;

  int tx_idle_pct = 18;
  int rx_idle_pct = 50;
  int cycles      = 0;

  line_pixel_rasterizer_top dut (.*);
  lpr_pixel_checker         u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver: random pop stalls
  always @(posedge clk)
    pop <= !rst && ($urandom_range(99) >= rx_idle_pct);

  // watchdog
  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // one input beat, after a random gap; returns at the accepting edge
  task automatic send_item(input logic o,
                           input logic signed [CRD_W-1:0] xa,
                           input logic signed [CRD_W-1:0] ya,
                           input logic signed [CRD_W-1:0] xb,
                           input logic signed [CRD_W-1:0] yb,
                           input logic [CLR_W-1:0] c);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    op         <= o;
    x_start    <= xa;
    y_start    <= ya;
    x_end      <= xb;
    y_end      <= yb;
    line_color <= c;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic step_noise();
    send_item(OP_STEP, CRD_W'($urandom), CRD_W'($urandom), CRD_W'($urandom),
              CRD_W'($urandom), CLR_W'($urandom));
  endtask

  // stop pushing, wait for every pixel, then let a last start settle
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pixels_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write; the caller drops psel after the last one
  task automatic write_reg(input reg_idx_t idx, input logic [DIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DAT_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  initial begin
    int x0, y0, x1, y1, len, steps, roll, used, done;
    logic [DIM_W-1:0] w, h;
    logic [CLR_W-1:0] c;

    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    push       <= 1'b0;
    op         <= OP_START;
    x_start    <= '0;
    y_start    <= '0;
    x_end      <= '0;
    y_end      <= '0;
    line_color <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset screen size 240x320
    // step with no active line is dropped
    send_item(OP_STEP, '0, '0, '0, '0, '0);
    // single-point line
    send_item(OP_START, 16'sd5, 16'sd7, 16'sd5, 16'sd7, 16'hFFFF);
    send_item(OP_STEP, '0, '0, '0, '0, '0);
    // step after the last pixel is dropped
    send_item(OP_STEP, '1, '1, '1, '1, '1);
    // corner to corner of the coordinate space
    send_item(OP_START, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'h0000);
    repeat (3) step_noise();
    // equal spans, endpoints given high to low
    send_item(OP_START, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'h07E0);
    repeat (2) step_noise();
    // steep line, axes swapped
    send_item(OP_START, 16'sd0, 16'sd0, 16'sd2, 16'sd5, 16'hF800);
    repeat (6) step_noise();
    // horizontal right to left, replaced by the next start midway
    send_item(OP_START, 16'sd10, 16'sd3, 16'sd4, 16'sd3, 16'h001F);
    repeat (2) step_noise();
    // across the far screen corner
    send_item(OP_START, 16'sd239, 16'sd319, 16'sd240, 16'sd320, 16'hAAAA);
    repeat (2) step_noise();

    // random lines, one screen size and idling pattern per phase
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       begin w = 13'd1;    h = 13'd1;    end
        1:       begin w = 13'd4096; h = 13'd4096; end
        2:       begin w = 13'd0;    h = 13'd0;    end
        3:       begin w = 13'd8191; h = 13'd8191; end
        4:       begin w = 13'd176;  h = 13'd4096; end
        default: begin w = 13'd240;  h = 13'd144;  end
      endcase
      tx_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 50 : 0;
      rx_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 18 : 0;
      drain();
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      psel    <= 1'b0;
      penable <= 1'b0;

      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        c    = CLR_W'($urandom);
        if (roll < 70) begin
          // short line near the screen
          x0 = int'($urandom_range(340)) - 40;
          y0 = int'($urandom_range(340)) - 40;
          x1 = x0 + int'($urandom_range(60)) - 30;
          y1 = y0 + int'($urandom_range(60)) - 30;
          if (roll < 10)
            y1 = y0;
          else if (roll < 20)
            x1 = x0;
          else if (roll < 28)
            y1 = (roll & 1) ? y0 + (x1 - x0) : y0 - (x1 - x0);
        end else if (roll < 85) begin
          // short line at the limits of the coordinate range
          x0 = $urandom_range(1) ? 32767 - int'($urandom_range(20))
                                 : -32768 + int'($urandom_range(20));
          y0 = $urandom_range(1) ? 32767 - int'($urandom_range(20))
                                 : -32768 + int'($urandom_range(20));
          x1 = (x0 > 0) ? 32767 - int'($urandom_range(20)) : -32768 + int'($urandom_range(20));
          y1 = (y0 > 0) ? 32767 - int'($urandom_range(20)) : -32768 + int'($urandom_range(20));
        end else begin
          // anywhere; long lines get cut short
          x0 = $signed(CRD_W'($urandom));
          y0 = $signed(CRD_W'($urandom));
          x1 = $signed(CRD_W'($urandom));
          y1 = $signed(CRD_W'($urandom));
        end
        len = ((span(x0, x1) > span(y0, y1)) ? span(x0, x1) : span(y0, y1)) + 1;

        // mostly whole lines, some cut short, some with surplus steps
        roll = $urandom_range(99);
        if (roll < 70)
          steps = len;
        else if (roll < 85)
          steps = $urandom_range(len - 1);
        else
          steps = len + int'($urandom_range(3, 1));
        if (steps > 48)
          steps = 48;

        send_item(OP_START, CRD_W'(x0), CRD_W'(y0), CRD_W'(x1), CRD_W'(y1), c);
        repeat (steps) step_noise();
        used = 1 + ((steps < len) ? steps : len);
        done += used;
      end
    end

    drain();
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
